>>> rtl/cmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmd_pkg: shared types and constants of the memo decoder
// Holds the status codes, the job codes that pass from front to back, and
// the memo length limit.
// ----------------------------------------------------------------------------
package cmd_pkg;

    localparam int MEMO_LEN_W      = 10;
    localparam int MAX_MEMO_BYTES_DEF = 1023;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_BAD_PARAM   = 2'd2,
        ST_BAD_STATE   = 2'd3
    } status_t;

    // Work handed from the front end to the back end.
    typedef enum logic [2:0] {
        JOB_NONE   = 3'd0,  // no character; only a chunk acknowledge if needed
        JOB_ERROR  = 3'd1,  // one error word
        JOB_CHAR   = 3'd2,  // one string byte passed through
        JOB_UINT   = 3'd3,  // decimal of the value
        JOB_NINT   = 3'd4   // minus sign and decimal of value plus one
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        status_t     status;
        logic [7:0]  ch;
        logic [63:0] value;
        logic        chunk_end;
    } job_t;

endpackage

>>> rtl/cbor_memo_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_memo_decoder: CBOR memo head decoder
// Byte-serial decoder of one CBOR data item into display characters.
// ----------------------------------------------------------------------------
// Each accepted memo word becomes one job in the front end's job register
// and, when it produces a single result word (string bytes, errors, chunk
// acknowledges), the back end loads that word into its output register, so
// strings stream at up to one word per cycle while words are popped.
// An integer head is converted to decimal by shift-and-add-three: once the
// back end takes the job it shifts in all 64 bits of the value and then
// finds the leading digit (the minus sign of a negative value is loaded as
// the job is taken), and the digits follow one per cycle while they are
// popped. New memo words wait in the one-entry job register meanwhile, and
// the input shows full while that register holds a job the back end does
// not take. Configure memo_length only while idle. An error result carries
// character zero; later words of a failed memo report an invalid-state
// error until a head word restarts the decoder.
// ----------------------------------------------------------------------------
module cbor_memo_decoder #(
    parameter int MAX_MEMO_BYTES = cmd_pkg::MAX_MEMO_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cmd_pkg::MEMO_LEN_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     data_byte,
    input  logic                           first_byte,
    input  logic                           chunk_last,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     out_char,
    output logic [1:0]                     status,
    output logic                           is_last,
    output logic                           more_wanted
);
    import cmd_pkg::*;

    // Counter wide enough for the memo length limit and the length register.
    localparam int CNT_W = ($clog2(MAX_MEMO_BYTES + 1) > MEMO_LEN_W)
                           ? $clog2(MAX_MEMO_BYTES + 1) : MEMO_LEN_W;

    logic  in_ready;
    logic  job_valid;
    logic  job_ready;
    job_t  job;
    logic  res_valid;

    assign full  = !in_ready;
    assign empty = !res_valid;

    cmd_front #(
        .MAX_MEMO_BYTES (MAX_MEMO_BYTES),
        .CNT_W          (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (push),
        .in_ready  (in_ready),
        .in_byte   (data_byte),
        .in_first  (first_byte),
        .in_chunk  (chunk_last),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    cmd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .res_valid  (res_valid),
        .res_ready  (pop),
        .res_char   (out_char),
        .res_status (status),
        .res_last   (is_last),
        .res_more   (more_wanted)
    );

endmodule

>>> rtl/cmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmd_front: head parser
// Accepts memo words, tracks the head and length bytes, and turns each word
// into one job for the back end.
// ----------------------------------------------------------------------------
module cmd_front #(
    parameter int MAX_MEMO_BYTES = cmd_pkg::MAX_MEMO_BYTES_DEF,
    parameter int CNT_W          = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cmd_pkg::MEMO_LEN_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          in_first,
    input  logic                          in_chunk,
    output logic                          job_valid,
    input  logic                          job_ready,
    output cmd_pkg::job_t                 job
);
    import cmd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD, PH_LEN, PH_STR, PH_INTDONE, PH_ERR
    } phase_t;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MEMO_BYTES);

    phase_t              phase_reg, phase_next;
    logic [2:0]          major_reg, major_next;
    logic [3:0]          left_reg, left_next;
    logic [63:0]         value_reg, value_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [MEMO_LEN_W-1:0] memo_len_reg;
    logic                job_valid_reg;
    job_t                job_reg, job_next;
    logic                take;
    logic [CNT_W-1:0]    memo_cnt;
    logic [4:0]          sc;

    assign in_ready  = !job_valid_reg || job_ready;
    assign take      = in_valid && in_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    assign sc        = in_byte[4:0];
    assign memo_cnt  = (CNT_W'(memo_len_reg) > MAX_CNT) ? MAX_CNT : CNT_W'(memo_len_reg);

    always_comb
    begin
        logic [63:0] v;
        logic [2:0]  mk;
        logic [CNT_W-1:0] rem;
        logic        head_done;
        phase_next  = phase_reg;
        major_next  = major_reg;
        left_next   = left_reg;
        value_next  = value_reg;
        remain_next = remain_reg;
        job_next.kind      = JOB_NONE;
        job_next.status    = ST_OK;
        job_next.ch        = in_byte;
        job_next.value     = '0;
        job_next.chunk_end = in_chunk;
        head_done = 1'b0;
        v   = value_reg;
        mk  = major_reg;
        rem = remain_reg;
        if (in_first) begin
            mk = in_byte[7:5];
            major_next = mk;
            left_next  = '0;
            value_next = '0;
            phase_next = PH_HEAD;
            if (memo_cnt == '0) begin
                remain_next = '0;
                job_next.kind = JOB_ERROR; job_next.status = ST_BAD_STATE;
                phase_next = PH_ERR;
            end else begin
                rem = memo_cnt - CNT_W'(1);
                remain_next = rem;
                if (sc < 5'd24) begin
                    v = {59'd0, sc};
                    value_next = v;
                    head_done = 1'b1;
                end else if (sc <= 5'd27) begin
                    left_next  = 4'd1 << sc[1:0];
                    phase_next = PH_LEN;
                end else if (sc == 5'd31) begin
                    job_next.kind = JOB_ERROR; job_next.status = ST_UNSUPPORTED;
                    phase_next = PH_ERR;
                end else begin
                    job_next.kind = JOB_ERROR; job_next.status = ST_BAD_PARAM;
                    phase_next = PH_ERR;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (remain_reg == '0) begin
                        job_next.kind = JOB_ERROR; job_next.status = ST_BAD_STATE;
                        phase_next = PH_ERR;
                    end else begin
                        rem = remain_reg - CNT_W'(1);
                        remain_next = rem;
                        v = {value_reg[55:0], in_byte};
                        value_next = v;
                        left_next = left_reg - 4'd1;
                        if (left_reg == 4'd1) head_done = 1'b1;
                    end
                end
                PH_STR:
                begin
                    if (remain_reg == '0) begin
                        job_next.kind = JOB_ERROR; job_next.status = ST_BAD_STATE;
                        phase_next = PH_ERR;
                    end else begin
                        remain_next = remain_reg - CNT_W'(1);
                        job_next.kind = JOB_CHAR;
                    end
                end
                PH_INTDONE:
                begin
                    job_next.kind = JOB_ERROR; job_next.status = ST_UNSUPPORTED;
                    phase_next = PH_ERR;
                end
                default:
                begin
                    job_next.kind = JOB_ERROR; job_next.status = ST_BAD_STATE;
                    phase_next = PH_ERR;
                end
            endcase
        end
        if (head_done) begin
            job_next.value = v;
            case (mk)
                3'd0, 3'd1:
                begin
                    if (rem != '0) begin
                        job_next.kind = JOB_ERROR; job_next.status = ST_BAD_STATE;
                        phase_next = PH_ERR;
                    end else begin
                        job_next.kind = (mk == 3'd0) ? JOB_UINT : JOB_NINT;
                        phase_next = PH_INTDONE;
                    end
                end
                3'd3:
                begin
                    if (64'(rem) != v) begin
                        job_next.kind = JOB_ERROR; job_next.status = ST_BAD_STATE;
                        phase_next = PH_ERR;
                    end else begin
                        phase_next = PH_STR;
                    end
                end
                default:
                begin
                    job_next.kind = JOB_ERROR; job_next.status = ST_UNSUPPORTED;
                    phase_next = PH_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_HEAD;
            major_reg     <= '0;
            left_reg      <= '0;
            value_reg     <= '0;
            remain_reg    <= '0;
            memo_len_reg  <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            if (cfg_we)
                memo_len_reg <= cfg_data;
            if (take) begin
                phase_reg  <= phase_next;
                major_reg  <= major_next;
                left_reg   <= left_next;
                value_reg  <= value_next;
                remain_reg <= remain_next;
            end
            if (in_ready)
                job_valid_reg <= in_valid && (in_chunk || job_next.kind != JOB_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_next;
    end

endmodule

>>> rtl/cmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmd_back: result generator
// Carries out one job at a time: passes characters and errors through and
// converts integers to decimal by shift-and-add-three over all 64 bits.
// ----------------------------------------------------------------------------
module cmd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  cmd_pkg::job_t  job,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [7:0]     res_char,
    output logic [1:0]     res_status,
    output logic           res_last,
    output logic           res_more
);
    import cmd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_FIND, S_EMIT, S_SUFFIX
    } state_t;

    localparam int NDIG = 20;

    state_t       state_reg;
    logic [63:0]  bin_reg;        // binary value, shifted out from the top
    logic [79:0]  bcd_reg;        // twenty decimal digits, least significant low
    logic [79:0]  bcd_adj;
    logic [5:0]   bit_reg;
    logic [4:0]   ndig_reg;       // index of the digit shown next
    logic [4:0]   top_idx;
    logic [3:0]   cur_digit;
    logic [2:0]   suf_reg;
    logic         chunk_reg;
    logic         neg_max_reg;
    logic         out_valid_reg;
    logic [7:0]   out_char_reg;
    logic [1:0]   out_status_reg;
    logic         out_last_reg;
    logic         out_more_reg;
    logic         out_free;
    logic         out_load;
    logic [7:0]   suffix_ch;

    assign out_free   = !out_valid_reg || res_ready;
    assign job_ready  = (state_reg == S_IDLE) && out_free;
    assign res_valid  = out_valid_reg;
    assign res_char   = out_char_reg;
    assign res_status = out_status_reg;
    assign res_last   = out_last_reg;
    assign res_more   = out_more_reg;
    assign cur_digit  = bcd_reg[{ndig_reg, 2'b00} +: 4];

    always_comb
    begin
        case (suf_reg)
            3'd0:    suffix_ch = 8'h20;
            3'd1:    suffix_ch = 8'h2d;
            3'd2:    suffix_ch = 8'h20;
            default: suffix_ch = 8'h31;
        endcase
    end

    // Every digit of five or more gets three added before the next shift.
    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // Highest nonzero digit; a zero value still shows one digit.
    always_comb
    begin
        top_idx = '0;
        for (int i = 1; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                top_idx = 5'(i);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:           out_load = out_free && job_valid && (job.kind != JOB_UINT);
            S_EMIT, S_SUFFIX: out_load = out_free;
            default:          out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            bin_reg        <= '0;
            bcd_reg        <= '0;
            bit_reg        <= '0;
            ndig_reg       <= '0;
            suf_reg        <= '0;
            chunk_reg      <= 1'b0;
            neg_max_reg    <= 1'b0;
            out_char_reg   <= '0;
            out_status_reg <= '0;
            out_last_reg   <= 1'b0;
            out_more_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && out_free)
                    begin
                        chunk_reg <= job.chunk_end;
                        unique case (job.kind) inside
                            JOB_UINT, JOB_NINT:
                            begin
                                neg_max_reg <= (job.kind == JOB_NINT) && (&job.value);
                                bin_reg <= (job.kind == JOB_NINT && !(&job.value))
                                           ? job.value + 64'd1 : job.value;
                                bcd_reg <= '0;
                                bit_reg <= '0;
                                suf_reg <= '0;
                                if (job.kind == JOB_NINT)
                                begin
                                    out_char_reg   <= 8'h2d;
                                    out_status_reg <= ST_OK;
                                    out_last_reg   <= 1'b0;
                                    out_more_reg   <= 1'b0;
                                end
                                state_reg <= S_CONV;
                            end
                            JOB_CHAR:
                            begin
                                out_char_reg   <= job.ch;
                                out_status_reg <= ST_OK;
                                out_last_reg   <= 1'b1;
                                out_more_reg   <= job.chunk_end;
                            end
                            JOB_ERROR:
                            begin
                                out_char_reg   <= '0;
                                out_status_reg <= job.status;
                                out_last_reg   <= 1'b1;
                                out_more_reg   <= 1'b0;
                            end
                            default:
                            begin
                                out_char_reg   <= '0;
                                out_status_reg <= ST_OK;
                                out_last_reg   <= 1'b1;
                                out_more_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CONV:
                begin
                    bcd_reg <= {bcd_adj[78:0], bin_reg[63]};
                    bin_reg <= {bin_reg[62:0], 1'b0};
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd63)
                        state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    ndig_reg  <= top_idx;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_char_reg   <= 8'h30 + {4'd0, cur_digit};
                        out_status_reg <= ST_OK;
                        if (ndig_reg == 5'd0)
                        begin
                            if (neg_max_reg)
                            begin
                                out_last_reg <= 1'b0;
                                out_more_reg <= 1'b0;
                                state_reg    <= S_SUFFIX;
                            end
                            else
                            begin
                                out_last_reg <= 1'b1;
                                out_more_reg <= chunk_reg;
                                state_reg    <= S_IDLE;
                            end
                        end
                        else
                        begin
                            ndig_reg     <= ndig_reg - 5'd1;
                            out_last_reg <= 1'b0;
                            out_more_reg <= 1'b0;
                        end
                    end
                end
                S_SUFFIX:
                begin
                    if (out_free)
                    begin
                        out_char_reg   <= suffix_ch;
                        out_status_reg <= ST_OK;
                        suf_reg        <= suf_reg + 3'd1;
                        out_last_reg   <= (suf_reg == 3'd3);
                        out_more_reg   <= (suf_reg == 3'd3) && chunk_reg;
                        if (suf_reg == 3'd3)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> test/cbor_memo_decoder_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_memo_decoder_check: result checker of the memo decoder
// Watches the configuration, memo and display channels. It works out the
// display words that each accepted memo word causes and compares them with
// the words the decoder delivers.
// ----------------------------------------------------------------------------
module cbor_memo_decoder_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cmd_pkg::MEMO_LEN_W-1:0] cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  logic [7:0]                     data_byte,
    input  logic                           first_byte,
    input  logic                           chunk_last,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [7:0]                     out_char,
    input  logic [1:0]                     status,
    input  logic                           is_last,
    input  logic                           more_wanted,
    output int                             fail_count,
    output int                             waiting
);
    import cmd_pkg::*;

    localparam int MAX_WORDS = 25;

    typedef enum logic [2:0] {
        WAIT_HEAD,
        IN_LENGTH,
        IN_TEXT,
        INT_DONE,
        FAILED
    } memo_phase_e;

    typedef struct {
        logic [7:0] ch;
        status_t    st;
        logic       last;
        logic       more;
    } disp_word_t;

    disp_word_t expected_words[$];
    disp_word_t step_words[$];

    logic [MEMO_LEN_W-1:0] memo_len;
    memo_phase_e           phase;
    logic [2:0]            major;
    logic [3:0]            len_left;
    logic [63:0]           len_value;
    logic [MEMO_LEN_W-1:0] bytes_left;

    function automatic void emit(logic [7:0] ch, status_t st);
        disp_word_t w;
        if (step_words.size() < MAX_WORDS)
        begin
            w.ch = ch;
            w.st = st;
            w.last = 1'b0;
            w.more = 1'b0;
            step_words.push_back(w);
        end
    endfunction

    function automatic void abort(status_t st);
        phase = FAILED;
        emit(8'd0, st);
    endfunction

    function automatic void emit_decimal(logic [63:0] v);
        logic [3:0] digits[20];
        int k;
        k = 0;
        do
        begin
            digits[k] = 4'(v % 10);
            k++;
            v = v / 10;
        end
        while (v != 0 && k < 20);
        while (k > 0)
        begin
            k--;
            emit(8'h30 + digits[k], ST_OK);
        end
    endfunction

    // The head is complete: integers print now, strings check their length.
    function automatic void close_head();
        case (major)
            3'd0:
            begin
                if (bytes_left != 0)
                begin
                    abort(ST_BAD_STATE);
                    return;
                end
                emit_decimal(len_value);
                phase = INT_DONE;
            end
            3'd1:
            begin
                if (bytes_left != 0)
                begin
                    abort(ST_BAD_STATE);
                    return;
                end
                emit("-", ST_OK);
                if (len_value == '1)
                begin
                    emit_decimal(len_value);
                    emit(" ", ST_OK);
                    emit("-", ST_OK);
                    emit(" ", ST_OK);
                    emit("1", ST_OK);
                end
                else
                begin
                    emit_decimal(len_value + 64'd1);
                end
                phase = INT_DONE;
            end
            3'd3:
            begin
                if (64'(bytes_left) != len_value)
                begin
                    abort(ST_BAD_STATE);
                    return;
                end
                phase = IN_TEXT;
            end
            default: abort(ST_UNSUPPORTED);
        endcase
    endfunction

    function automatic void decode_memo_word(logic [7:0] b, logic first, logic chunk);
        logic [4:0] short_count;
        short_count = b[4:0];
        step_words.delete();
        if (first)
        begin
            len_value = '0;
            len_left = '0;
            bytes_left = memo_len;
            major = b[7:5];
            phase = WAIT_HEAD;
            if (bytes_left == 0)
            begin
                abort(ST_BAD_STATE);
            end
            else
            begin
                bytes_left--;
                if (short_count < 24)
                begin
                    len_value = 64'(short_count);
                    close_head();
                end
                else if (short_count <= 27)
                begin
                    len_left = 4'd1 << short_count[1:0];
                    phase = IN_LENGTH;
                end
                else if (short_count == 31)
                begin
                    abort(ST_UNSUPPORTED);
                end
                else
                begin
                    abort(ST_BAD_PARAM);
                end
            end
        end
        else
        begin
            case (phase)
                IN_LENGTH:
                begin
                    if (bytes_left == 0)
                    begin
                        abort(ST_BAD_STATE);
                    end
                    else
                    begin
                        bytes_left--;
                        len_value = {len_value[55:0], b};
                        len_left--;
                        if (len_left == 0)
                            close_head();
                    end
                end
                IN_TEXT:
                begin
                    if (bytes_left == 0)
                    begin
                        abort(ST_BAD_STATE);
                    end
                    else
                    begin
                        bytes_left--;
                        emit(b, ST_OK);
                    end
                end
                INT_DONE: abort(ST_UNSUPPORTED);
                default:  abort(ST_BAD_STATE);
            endcase
        end
        // A chunk end that causes nothing still gets an acknowledge word.
        if (step_words.size() == 0 && chunk)
            emit(8'd0, ST_OK);
        if (step_words.size() > 0)
        begin
            step_words[$].last = 1'b1;
            step_words[$].more = chunk && step_words[$].st == ST_OK;
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        disp_word_t want;
        if (!rst_n)
        begin
            memo_len = '0;
            phase = WAIT_HEAD;
            major = '0;
            len_left = '0;
            len_value = '0;
            bytes_left = '0;
            expected_words.delete();
            fail_count = 0;
            waiting = 0;
        end
        else
        begin
            if (cfg_we)
                memo_len = cfg_data;
            if (push && !full)
                decode_memo_word(data_byte, first_byte, chunk_last);
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected display word: char %h status %0d", out_char, status);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_char !== want.ch || status !== want.st
                        || is_last !== want.last || more_wanted !== want.more)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("word mismatch: want char %h st %0d last %b more %b,",
                                     want.ch, want.st, want.last, want.more,
                                     " got char %h st %0d last %b more %b",
                                     out_char, status, is_last, more_wanted);
                    end
                end
            end
            waiting = expected_words.size();
        end
    end

endmodule

>>> test/cbor_memo_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_memo_decoder_test: testbench of the CBOR memo decoder
// Drives memo words and memo length settings into the decoder, pops display
// words with random stalls, and leaves the checking to a checker module that
// sits beside the decoder. A directed set of memos comes first, then random
// memos, mostly well formed, with some broken ones and noise.
// ----------------------------------------------------------------------------
module cbor_memo_decoder_test;
    import cmd_pkg::*;

    // Once every expected display word has been popped the decoder is idle;
    // the settle wait keeps the memo length write well clear of it.
    localparam int SETTLE_CYCLES = 2;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [MEMO_LEN_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    logic [7:0]            data_byte;
    logic                  first_byte;
    logic                  chunk_last;
    logic                  empty;
    logic                  pop;
    logic [7:0]            out_char;
    logic [1:0]            status;
    logic                  is_last;
    logic                  more_wanted;
    int                    fail_count;
    int                    waiting;

    int  cycles;
    int  random_sent;
    bit  quiet;
    int  pop_stall;

    cbor_memo_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .chunk_last  (chunk_last),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .status      (status),
        .is_last     (is_last),
        .more_wanted (more_wanted)
    );

    cbor_memo_decoder_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .chunk_last  (chunk_last),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .status      (status),
        .is_last     (is_last),
        .more_wanted (more_wanted),
        .fail_count  (fail_count),
        .waiting     (waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // The display side stalls in short random bursts, except near the end.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (quiet)
        begin
            pop <= 1'b1;
        end
        else if (pop_stall > 0)
        begin
            pop_stall--;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            pop_stall = $urandom_range(0, 2);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Sends one memo word and returns at the edge that accepts it. The push
    // stays high between back-to-back words unless an idle burst is drawn.
    task automatic send_word(logic [7:0] b, logic first, logic chunk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        first_byte <= first;
        chunk_last <= chunk;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stops sending, lets every expected display word drain and the back end
    // go quiet, and optionally loads a new memo length while the decoder idles.
    task automatic drain_and_set_length(bit do_write, int unsigned len);
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (do_write)
        begin
            cfg_we <= 1'b1;
            cfg_data <= MEMO_LEN_W'(len);
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // One memo: a head of the given major type, a big-endian length of
    // len_bytes bytes (none means the short count carries the value), and
    // body_len random content bytes. Chunk ends fall at random.
    task automatic send_memo(logic [2:0] kind, int len_bytes, logic [63:0] value,
                             int body_len, ref int counter);
        logic [4:0] short_count;
        case (len_bytes)
            1:       short_count = 5'd24;
            2:       short_count = 5'd25;
            4:       short_count = 5'd26;
            8:       short_count = 5'd27;
            default: short_count = value[4:0];
        endcase
        send_word({kind, short_count}, 1'b1, $urandom_range(0, 3) == 0);
        for (int i = len_bytes - 1; i >= 0; i--)
            send_word(value[8*i +: 8], 1'b0, $urandom_range(0, 3) == 0);
        for (int i = 0; i < body_len; i++)
            send_word(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
        counter += 1 + len_bytes + body_len;
    endtask

    task automatic random_memos();
        int unsigned pick;
        int          len_bytes;
        int          body;
        int          extra;
        logic [2:0]  kind;
        logic [63:0] value;
        int          dummy;
        while (random_sent < RANDOM_WORDS)
        begin
            quiet = random_sent > RANDOM_WORDS - 25;
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 4))
                0:       len_bytes = 0;
                1:       len_bytes = 1;
                2:       len_bytes = 2;
                3:       len_bytes = 4;
                default: len_bytes = 8;
            endcase
            value = {$urandom, $urandom};
            if (len_bytes == 0)
                value = 64'($urandom_range(0, 23));
            else if (len_bytes < 8)
                value = value & ((64'd1 << (8 * len_bytes)) - 1);
            if ($urandom_range(0, 9) == 0 && len_bytes != 0)
                value = len_bytes == 8 ? '1 : (64'd1 << (8 * len_bytes)) - 1;
            // A memo length that is off by one or two exercises the mismatch paths.
            extra = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 0;
            if (pick < 45)
            begin
                // Text string whose length field matches its body.
                body = $urandom_range(0, 12);
                if (len_bytes == 0 && body > 23)
                    body = 23;
                value = 64'(body);
                drain_and_set_length(1'b1, 1 + len_bytes + body + extra);
                repeat ($urandom_range(1, 2))
                    send_memo(3'd3, len_bytes, value, body, random_sent);
            end
            else if (pick < 85)
            begin
                // Unsigned or negative integer, sometimes with a stray byte.
                kind = 3'($urandom_range(0, 1));
                drain_and_set_length(1'b1, 1 + len_bytes + extra);
                send_memo(kind, len_bytes, value, ($urandom_range(0, 9) == 0) ? 1 : 0,
                          random_sent);
            end
            else
            begin
                // Noise: any head, any byte, any memo length.
                drain_and_set_length(1'b1, $urandom_range(0, 20));
                repeat ($urandom_range(3, 8))
                begin
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                              1'($urandom_range(0, 1)));
                    random_sent++;
                end
            end
        end
    endtask

    initial
    begin
        int directed;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        data_byte = '0;
        first_byte = 1'b0;
        chunk_last = 1'b0;
        cycles = 0;
        random_sent = 0;
        quiet = 1'b0;
        pop_stall = 0;
        directed = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A word before any head, then a head while the memo length is zero.
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);

        // One-byte memos: smallest and largest short counts, a trailing byte
        // after an integer and the error that follows it, the reserved and
        // indefinite short counts, an unsupported type, a length past the end.
        drain_and_set_length(1'b1, 1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h17, 1'b1, 1'b1);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'haa, 1'b0, 1'b1);
        send_word(8'h20, 1'b1, 1'b0);
        send_word(8'h1f, 1'b1, 1'b0);
        send_word(8'h1c, 1'b1, 1'b0);
        send_word(8'h5e, 1'b1, 1'b0);
        send_word(8'h40, 1'b1, 1'b0);
        send_word(8'h18, 1'b1, 1'b0);
        send_word(8'h07, 1'b0, 1'b0);

        // Largest value both signed and unsigned, and the negative smallest.
        drain_and_set_length(1'b1, 9);
        send_memo(3'd0, 8, '1, 0, directed);
        send_memo(3'd1, 8, '1, 0, directed);
        send_memo(3'd1, 8, '0, 0, directed);

        // Largest memo length: an integer with bytes left, and a string length
        // that only differs from the bytes left in its upper bits.
        drain_and_set_length(1'b1, 1023);
        send_word(8'h01, 1'b1, 1'b0);
        send_memo(3'd3, 8, 64'hffff_ffff_0000_03f6, 0, directed);

        // A short, well-formed text string.
        drain_and_set_length(1'b1, 4);
        send_memo(3'd3, 0, 64'd3, 3, directed);

        random_memos();

        drain_and_set_length(1'b0, 0);
        if (fail_count == 0 && waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
